// ===== hw/rtl/u8mv_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 message validator.
// No dependencies; imported by u8mv_step, utf8_message_validator_top, utf8_verdict_checker and tb_top.
`timescale 1ns / 1ps

package u8mv_pkg;

    localparam int CntW = 13;
    localparam int LimW = 12;
    localparam int CpW  = 21;

    localparam logic [CntW-1:0] SAT_MAX = 13'd4096;

    localparam logic [LimW-1:0] BYTE_LIMIT_RST = 12'd768;
    localparam logic [LimW-1:0] CHAR_LIMIT_RST = 12'd200;

    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic REG_CHAR_LIMIT = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_TOO_LONG   = 3'd2;
    localparam logic [2:0] ST_BAD_UTF8   = 3'd3;
    localparam logic [2:0] ST_TOO_MANY_CP = 3'd4;

    typedef struct packed {
        logic            seen_text;
        logic [1:0]      bytes_left_in_seq;
        logic [2:0]      seq_width;
        logic [CpW-1:0]  partial_code_point;
        logic            bad_utf8;
        logic [CntW-1:0] byte_total;
        logic [CntW-1:0] char_total;
        logic [CntW-1:0] pending_space_run;
        logic            pending_has_newline;
    } t_state;

    typedef struct packed {
        logic [2:0]      status;
        logic [CntW-1:0] char_count;
        logic [CntW-1:0] trimmed_bytes;
    } t_result;

    function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                                input logic [CntW-1:0] b);
        logic [CntW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, SAT_MAX}) ? SAT_MAX : s[CntW-1:0];
    endfunction

endpackage

// ===== hw/rtl/u8mv_step.sv =====
// Per-word update of the message state and the verdict at the last word.
// Depends on u8mv_pkg.
`timescale 1ns / 1ps

module u8mv_step (
    input  u8mv_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_present,
    input  logic              i_last,
    input  logic [11:0]       i_byte_limit,
    input  logic [11:0]       i_char_limit,
    output u8mv_pkg::t_state  o_state,
    output u8mv_pkg::t_result o_result
);
    import u8mv_pkg::*;

    function automatic logic cp_bad(input logic [CpW-1:0] cp, input logic [2:0] w);
        logic overlong;
        overlong = (w == 3'd2 && cp < 21'h80) || (w == 3'd3 && cp < 21'h800) ||
                   (w == 3'd4 && cp < 21'h10000);
        return overlong || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF) ||
               (cp < 21'h20 && cp != 21'h09) || cp == 21'h7F;
    endfunction

    t_state  n;
    t_result res;
    logic    is_space;
    logic    do_finish;

    always_comb begin
        n         = i_state;
        do_finish = 1'b0;
        is_space  = i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0D ||
                    i_byte == 8'h0A;
        if (i_present) begin
            if (is_space) begin
                if (n.seen_text) begin
                    n.pending_space_run = sat_add(n.pending_space_run, 13'd1);
                    if (i_byte == 8'h0D || i_byte == 8'h0A) begin
                        n.pending_has_newline = 1'b1;
                    end
                end
            end else begin
                n.seen_text = 1'b1;
                if (n.pending_space_run != '0) begin
                    n.byte_total = sat_add(n.byte_total, n.pending_space_run);
                    if (!n.bad_utf8) begin
                        if (n.bytes_left_in_seq != 2'd0 || n.pending_has_newline) begin
                            n.bad_utf8 = 1'b1;
                        end else begin
                            n.char_total = sat_add(n.char_total, n.pending_space_run);
                        end
                    end
                    n.pending_space_run   = '0;
                    n.pending_has_newline = 1'b0;
                end
                n.byte_total = sat_add(n.byte_total, 13'd1);
                if (!n.bad_utf8) begin
                    if (n.bytes_left_in_seq == 2'd0) begin
                        if (i_byte <= 8'h7F) begin
                            n.seq_width          = 3'd1;
                            n.partial_code_point = {13'd0, i_byte};
                            do_finish            = 1'b1;
                        end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                            n.seq_width          = 3'd2;
                            n.bytes_left_in_seq  = 2'd1;
                            n.partial_code_point = {16'd0, i_byte[4:0]};
                        end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                            n.seq_width          = 3'd3;
                            n.bytes_left_in_seq  = 2'd2;
                            n.partial_code_point = {17'd0, i_byte[3:0]};
                        end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                            n.seq_width          = 3'd4;
                            n.bytes_left_in_seq  = 2'd3;
                            n.partial_code_point = {18'd0, i_byte[2:0]};
                        end else begin
                            n.bad_utf8 = 1'b1;
                        end
                    end else if (i_byte[7:6] != 2'b10) begin
                        n.bad_utf8 = 1'b1;
                    end else begin
                        n.partial_code_point = {n.partial_code_point[14:0], i_byte[5:0]};
                        n.bytes_left_in_seq  = n.bytes_left_in_seq - 2'd1;
                        do_finish            = n.bytes_left_in_seq == 2'd0;
                    end
                end
                if (do_finish) begin
                    if (cp_bad(n.partial_code_point, n.seq_width)) begin
                        n.bad_utf8 = 1'b1;
                    end else begin
                        n.char_total = sat_add(n.char_total, 13'd1);
                    end
                end
            end
        end

        res = '0;
        if (!n.seen_text) begin
            res.status = ST_EMPTY;
        end else begin
            res.trimmed_bytes = n.byte_total;
            if (n.byte_total > {1'b0, i_byte_limit}) begin
                res.status = ST_TOO_LONG;
            end else if (n.bad_utf8 || n.bytes_left_in_seq != 2'd0) begin
                res.status = ST_BAD_UTF8;
            end else if (n.char_total > {1'b0, i_char_limit}) begin
                res.status = ST_TOO_MANY_CP;
            end else begin
                res.status = ST_OK;
            end
            if (res.status == ST_OK || res.status == ST_TOO_MANY_CP) begin
                res.char_count = n.char_total;
            end
        end

        o_result = res;
        o_state  = i_last ? '0 : n;
    end

endmodule

// ===== hw/rtl/utf8_message_validator_top.sv =====
// Top level of the UTF-8 message validator: input register, state update, result register.
// Depends on u8mv_pkg and u8mv_step.
`timescale 1ns / 1ps

// Takes one message byte per word and returns one verdict word for each word marked
// tlast. Each word is registered, then checked and counted combinationally against the
// running message state, so a word can be accepted every clock cycle unless the input
// is stalled; the verdict is loaded into the output register at the edge that takes
// its word out of the input register. Only a last word waiting on an unread verdict
// stalls the input. The user must write limits through the configuration channel only
// while no message is in flight; the block itself does not enforce this.
module utf8_message_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [2:0] status, [15:3] char_count, [28:16] trimmed_bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import u8mv_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_present;
    logic        r_in_last;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_result     r_result;
    logic        r_out_valid;
    logic [11:0] r_byte_limit;
    logic [11:0] r_char_limit;
    logic        out_free;
    logic        proc_fire;

    assign out_free   = !r_out_valid || i_m_tready;
    assign proc_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || proc_fire;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_result.trimmed_bytes, r_result.char_count, r_result.status};

    u8mv_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_present    (r_in_present),
        .i_last       (r_in_last),
        .i_byte_limit (r_byte_limit),
        .i_char_limit (r_char_limit),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_byte_limit <= BYTE_LIMIT_RST;
            r_char_limit <= CHAR_LIMIT_RST;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (proc_fire) begin
                r_state <= n_state;
            end
            if (proc_fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_BYTE_LIMIT) begin
                    r_byte_limit <= i_cfg_data;
                end else if (i_cfg_index == REG_CHAR_LIMIT) begin
                    r_char_limit <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte    <= i_s_tdata;
            r_in_present <= i_s_tuser;
            r_in_last    <= i_s_tlast;
        end
        if (proc_fire && r_in_last) begin
            r_result <= n_result;
        end
    end

    a_mid_word_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_last |-> proc_fire)
        else $error("non-last word stalled in the input register");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_last |=> r_state.seen_text == 1'b0 && r_state.byte_total == '0 &&
                                   r_state.pending_space_run == '0)
        else $error("message state not cleared after verdict");

    a_counters_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_total <= SAT_MAX && r_state.char_total <= SAT_MAX &&
        r_state.pending_space_run <= SAT_MAX)
        else $error("counter went past saturation");

    a_verdict_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_last |=> r_out_valid)
        else $error("verdict not loaded into result register");

endmodule

// ===== sim/utf8_verdict_checker.sv =====
// Checker for the UTF-8 message validator: tracks limit writes, predicts one verdict
// per message from the accepted input words and compares every verdict word it sees.
// Depends on u8mv_pkg for the status codes and register indexes.
`timescale 1ns / 1ps

module utf8_verdict_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import u8mv_pkg::*;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] chars;
        logic [12:0] len;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [11:0] byte_lim;
    logic [11:0] char_lim;

    logic        seen;
    logic [1:0]  cont_left;
    logic [2:0]  seq_w;
    logic [20:0] cp;
    logic        utf8_bad;
    logic [12:0] n_bytes;
    logic [12:0] n_chars;
    logic [12:0] n_space;
    logic        space_nl;

    function automatic logic [12:0] sat_sum(input logic [12:0] a, input logic [12:0] b);
        logic [13:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 14'd4096)
            s = 14'd4096;
        return s[12:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    task automatic clear_message();
        seen      = 1'b0;
        cont_left = '0;
        seq_w     = '0;
        cp        = '0;
        utf8_bad  = 1'b0;
        n_bytes   = '0;
        n_chars   = '0;
        n_space   = '0;
        space_nl  = 1'b0;
    endtask

    task automatic close_code_point();
        logic overlong;
        overlong = (seq_w == 3'd2 && cp < 21'h80) || (seq_w == 3'd3 && cp < 21'h800) ||
                   (seq_w == 3'd4 && cp < 21'h10000);
        if (overlong || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF) ||
            (cp < 21'h20 && cp != 21'h09) || cp == 21'h7F)
            utf8_bad = 1'b1;
        else
            n_chars = sat_sum(n_chars, 13'd1);
    endtask

    task automatic decode_octet(input logic [7:0] b);
        if (!utf8_bad) begin
            if (cont_left == 2'd0) begin
                if (b <= 8'h7F) begin
                    seq_w = 3'd1;
                    cp    = {13'd0, b};
                    close_code_point();
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_w     = 3'd2;
                    cont_left = 2'd1;
                    cp        = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    seq_w     = 3'd3;
                    cont_left = 2'd2;
                    cp        = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    seq_w     = 3'd4;
                    cont_left = 2'd3;
                    cp        = {18'd0, b[2:0]};
                end else begin
                    utf8_bad = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                utf8_bad = 1'b1;
            end else begin
                cp        = {cp[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_code_point();
            end
        end
    endtask

    // Inner whitespace only counts once text follows it.
    task automatic flush_spaces();
        if (n_space != 13'd0) begin
            n_bytes = sat_sum(n_bytes, n_space);
            if (!utf8_bad) begin
                if (cont_left != 2'd0 || space_nl)
                    utf8_bad = 1'b1;
                else
                    n_chars = sat_sum(n_chars, n_space);
            end
            n_space  = '0;
            space_nl = 1'b0;
        end
    endtask

    task automatic take_octet(input logic [7:0] b);
        if (is_blank(b)) begin
            if (seen) begin
                n_space = sat_sum(n_space, 13'd1);
                if (b == CH_CR || b == CH_LF)
                    space_nl = 1'b1;
            end
        end else begin
            seen = 1'b1;
            flush_spaces();
            n_bytes = sat_sum(n_bytes, 13'd1);
            decode_octet(b);
        end
    endtask

    task automatic close_message(output t_verdict v);
        v = '0;
        if (!seen) begin
            v.status = ST_EMPTY;
        end else begin
            v.len = n_bytes;
            if (n_bytes > {1'b0, byte_lim})
                v.status = ST_TOO_LONG;
            else if (utf8_bad || cont_left != 2'd0)
                v.status = ST_BAD_UTF8;
            else if (n_chars > {1'b0, char_lim})
                v.status = ST_TOO_MANY_CP;
            else
                v.status = ST_OK;
            if (v.status == ST_OK || v.status == ST_TOO_MANY_CP)
                v.chars = n_chars;
        end
        clear_message();
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            clear_message();
            byte_lim = BYTE_LIMIT_RST;
            char_lim = CHAR_LIMIT_RST;
            verdict_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser)
                    take_octet(i_s_tdata);
                if (i_s_tlast) begin
                    close_message(want);
                    verdict_q.push_back(want);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[2:0];
                got.chars  = i_m_tdata[15:3];
                got.len    = i_m_tdata[28:16];
                if (verdict_q.size() == 0) begin
                    $error("verdict word %h with no message outstanding", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    o_checked++;
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.chars != want.chars) begin
                        $error("char_count: expected %0d, got %0d", want.chars, got.chars);
                        o_fail_count++;
                    end
                    if (got.len != want.len) begin
                        $error("trimmed_bytes: expected %0d, got %0d", want.len, got.len);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BYTE_LIMIT)
                    byte_lim = i_cfg_data;
                else
                    char_lim = i_cfg_data;
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the UTF-8 message validator: clock, reset, message stimulus,
// limit writes and ready pressure; verdicts are checked by utf8_verdict_checker.
// Depends on u8mv_pkg, utf8_message_validator_top and utf8_verdict_checker.
`timescale 1ns / 1ps

module tb_top;
    import u8mv_pkg::*;

    typedef struct packed {
        logic [7:0] octet;
        logic       present;
        logic       last;
    } t_word;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_data  = 12'h000;
    logic        hold_kick = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int real_words = 0;
    int msgs_sent  = 0;
    int settings_used = 0;

    t_word msg_q[$];

    utf8_message_validator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    utf8_verdict_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off once kicked.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_kick) begin
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void put(input logic [7:0] b, input logic last);
        msg_q.push_back('{octet: b, present: 1'b1, last: last});
    endfunction

    function automatic void put_void(input logic last);
        msg_q.push_back('{octet: 8'($urandom), present: 1'b0, last: last});
    endfunction

    function automatic void add_blank(input bit allow_nl);
        case ($urandom_range(allow_nl ? 3 : 1))
            0: put(8'h20, 1'b0);
            1: put(8'h09, 1'b0);
            2: put(8'h0D, 1'b0);
            default: put(8'h0A, 1'b0);
        endcase
    endfunction

    function automatic logic [20:0] rand_cp();
        logic [20:0] c;
        case ($urandom_range(5))
            0, 1: c = 21'($urandom_range(8'h21, 8'h7E));
            2: c = 21'($urandom_range(32'h80, 32'h7FF));
            3: begin
                c = 21'($urandom_range(32'h800, 32'hFFFF));
                if (c >= 21'hD800 && c <= 21'hDFFF)
                    c = c - 21'h800;
            end
            4: c = 21'($urandom_range(32'h10000, 32'h10FFFF));
            default: begin
                case ($urandom_range(9))
                    0: c = 21'h21;
                    1: c = 21'h7E;
                    2: c = 21'h80;
                    3: c = 21'h7FF;
                    4: c = 21'h800;
                    5: c = 21'hD7FF;
                    6: c = 21'hE000;
                    7: c = 21'hFFFF;
                    8: c = 21'h10000;
                    default: c = 21'h10FFFF;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic void add_code_point(input logic [20:0] c);
        if (c < 21'h80) begin
            put(c[7:0], 1'b0);
        end else if (c < 21'h800) begin
            put({3'b110, c[10:6]}, 1'b0);
            put({2'b10, c[5:0]}, 1'b0);
        end else if (c < 21'h10000) begin
            put({4'b1110, c[15:12]}, 1'b0);
            put({2'b10, c[11:6]}, 1'b0);
            put({2'b10, c[5:0]}, 1'b0);
        end else begin
            put({5'b11110, c[20:18]}, 1'b0);
            put({2'b10, c[17:12]}, 1'b0);
            put({2'b10, c[11:6]}, 1'b0);
            put({2'b10, c[5:0]}, 1'b0);
        end
    endfunction

    function automatic void add_text();
        int n;
        repeat ($urandom_range(0, 3)) add_blank(1'b1);
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            add_code_point(rand_cp());
            if (i < n - 1 && $urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) add_blank(1'b0);
        end
        repeat ($urandom_range(0, 3)) add_blank(1'b1);
    endfunction

    function automatic void damage_text();
        int idx;
        t_word w;
        idx = $urandom_range(0, msg_q.size() - 1);
        w   = msg_q[idx];
        case ($urandom_range(3))
            0: begin
                w.octet = 8'($urandom);
                msg_q[idx] = w;
            end
            1: if (msg_q.size() > 1) msg_q.delete(idx);
            2: begin
                w.octet = ($urandom_range(1) != 0) ? 8'h0A : 8'h0D;
                msg_q.insert(idx, w);
            end
            default: begin
                w.octet = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                                   : 8'($urandom_range(8'h00, 8'h1F));
                msg_q.insert(idx, w);
            end
        endcase
    endfunction

    function automatic void make_random_msg();
        int pick;
        t_word w;
        pick = $urandom_range(99);
        if (pick < 85) begin
            add_text();
            if (pick >= 60)
                damage_text();
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(7) == 0)
                    put_void(1'b0);
                else
                    put(8'($urandom), 1'b0);
            end
        end else begin
            repeat ($urandom_range(0, 4)) add_blank(1'b1);
        end
        if (msg_q.size() != 0 && $urandom_range(9) == 0)
            msg_q.insert($urandom_range(0, msg_q.size() - 1),
                         '{octet: 8'($urandom), present: 1'b0, last: 1'b0});
        if (msg_q.size() == 0 || $urandom_range(7) == 0) begin
            put_void(1'b1);
        end else begin
            w = msg_q[msg_q.size() - 1];
            w.last = 1'b1;
            msg_q[msg_q.size() - 1] = w;
        end
    endfunction

    task automatic send_msg();
        int gap;
        bit taken;
        t_word w;
        while (msg_q.size() != 0) begin
            w   = msg_q.pop_front();
            gap = 0;
            while ($urandom_range(99) < idle_pct && gap < 40)
                gap++;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w.octet;
            s_tuser  <= w.present;
            s_tlast  <= w.last;
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                taken = s_tready;
                @(posedge i_clk);
            end
            if (w.present || w.last)
                real_words++;
            if (w.last)
                msgs_sent++;
        end
    endtask

    task automatic set_limits(input logic [11:0] byte_lim, input logic [11:0] char_lim);
        bit taken;
        for (int k = 0; k < 2; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (k == 0) ? REG_BYTE_LIMIT : REG_CHAR_LIMIT;
            cfg_data  <= (k == 0) ? byte_lim : char_lim;
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                taken = cfg_ready;
                @(posedge i_clk);
            end
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [11:0] byte_lim, input logic [11:0] char_lim,
                             input int ip, input int sp, input int n_words,
                             input bit long_hold);
        int start;
        idle_pct  = ip;
        stall_pct <= sp;
        set_limits(byte_lim, char_lim);
        if (long_hold) begin
            hold_kick <= 1'b1;
            @(posedge i_clk);
            hold_kick <= 1'b0;
        end
        start = real_words;
        while (real_words - start < n_words) begin
            make_random_msg();
            send_msg();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed messages under the reset limits.
        put_void(1'b1);
        put_void(1'b0);
        put(8'h41, 1'b1);
        put(8'h09, 1'b0); put(8'h61, 1'b0); put(8'h0A, 1'b1);
        put(8'hF4, 1'b0); put(8'h8F, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b1);
        put(8'hE0, 1'b0); put(8'h9F, 1'b0); put(8'hBF, 1'b1);
        put(8'hED, 1'b0); put(8'hA0, 1'b0); put(8'h80, 1'b1);
        put(8'h61, 1'b0); put(8'h0A, 1'b0); put(8'h62, 1'b1);
        put(8'h7F, 1'b1);
        put(8'hE2, 1'b0); put(8'h20, 1'b0); put(8'h82, 1'b1);
        put(8'h20, 1'b1);
        put(8'h78, 1'b0); put_void(1'b1);
        send_msg();
        drain();

        run_phase(12'd4095, 12'd4095, 0, 0, 350, 1'b0);
        run_phase(12'd1, 12'd1, 68, 0, 250, 1'b0);
        run_phase(12'($urandom_range(1, 60)), 12'($urandom_range(1, 40)), 0, 68, 350, 1'b1);
        run_phase(12'($urandom_range(1, 80)), 12'($urandom_range(1, 50)), 25, 25, 450, 1'b0);

        // Messages right at and just past the limits, and one with a long inner space run.
        idle_pct  = 0;
        stall_pct <= 25;
        set_limits(12'd64, 12'd48);
        repeat (63) put(8'h61, 1'b0);
        put(8'h62, 1'b1);
        repeat (64) put(8'h61, 1'b0);
        put(8'h62, 1'b1);
        put(8'h61, 1'b0);
        repeat (40) put(8'h20, 1'b0);
        put(8'h62, 1'b1);
        repeat (47) put(8'h61, 1'b0);
        put(8'h62, 1'b1);
        send_msg();
        drain();

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d words in %0d messages under %0d limit settings;",
                 real_words, msgs_sent, settings_used);
        $display("%0d verdicts compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
